// File: sv/assert_macros.svh
// Assertion helpers used by the controller top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

// File: sv/scac_pkg.sv
// ----------------------------------------------------------------------------
// scac_pkg
// Shared types and defaults of the set-associative cache controller.
// ----------------------------------------------------------------------------
package scac_pkg;

	localparam int LINE_BYTES_DEF = 64;
	localparam int SETS_DEF       = 64;
	localparam int WAYS_DEF       = 4;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_UPD,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic        hit;
		logic        last;
	} out_item_t;

	// status handed from the back part to the front part
	typedef struct packed {
		logic clearing;
		logic pop;
	} back_stat_t;

	localparam logic [2:0] REG_WRITE_POLICY = 3'd0;

endpackage

// File: sv/scac_ram.sv
// ----------------------------------------------------------------------------
// scac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: sv/scac_front.sv
// ----------------------------------------------------------------------------
// scac_front
// Accept accesses, split the address into set and tag, queue them.
// ----------------------------------------------------------------------------
module scac_front #(
	parameter int SET_W = 6,
	parameter int TAG_W = 20,
	parameter int LINE_BYTES = 64,
	parameter int SETS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [31:0]          access_address,
	input  scac_pkg::back_stat_t stat,
	output logic                 q_valid,
	output logic                 q_wr,
	output logic [31:0]          q_addr,
	output logic [SET_W-1:0]     q_set,
	output logic [TAG_W-1:0]     q_tag
);
	import scac_pkg::*;

	logic              wr_q   [2];
	logic [31:0]       addr_q [2];
	logic [SET_W-1:0]  set_q  [2];
	logic [TAG_W-1:0]  tag_q  [2];
	logic              wptr_q, rptr_q;
	logic [1:0]        cnt_q;
	logic [31:0]       blk;
	logic              do_push;

	assign full    = (cnt_q == 2'd2) || stat.clearing;
	assign do_push = push && !full;
	assign blk     = access_address / LINE_BYTES;

	assign q_valid = (cnt_q != 2'd0);
	assign q_wr    = wr_q[rptr_q];
	assign q_addr  = addr_q[rptr_q];
	assign q_set   = set_q[rptr_q];
	assign q_tag   = tag_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			wr_q[wptr_q]   <= action;
			addr_q[wptr_q] <= access_address;
			set_q[wptr_q]  <= SET_W'(blk % SETS);
			tag_q[wptr_q]  <= TAG_W'(blk / SETS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (stat.pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(stat.pop);
		end
	end
endmodule

// File: sv/scac_outq.sv
// ----------------------------------------------------------------------------
// scac_outq
// Four-entry result queue toward the consumer.
// ----------------------------------------------------------------------------
module scac_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wen,
	input  scac_pkg::out_item_t wdata,
	output logic                wfull,
	input  logic                pop,
	output logic                empty,
	output scac_pkg::out_item_t head
);
	import scac_pkg::*;

	out_item_t  buf_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;
	logic       do_w, do_r;

	assign wfull = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign head  = buf_q[rptr_q];
	assign do_w  = wen && !wfull;
	assign do_r  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_w) buf_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (do_w) wptr_q <= wptr_q + 2'd1;
			if (do_r) rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(do_w) - 3'(do_r);
		end
	end
endmodule

// File: sv/scac_back.sv
// ----------------------------------------------------------------------------
// scac_back
// Look up one set, choose hit or victim, update the set, emit results.
// ----------------------------------------------------------------------------
module scac_back #(
	parameter int SET_W = 6,
	parameter int TAG_W = 20,
	parameter int LINE_BYTES = 64,
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_policy,
	input  logic                 q_valid,
	input  logic                 q_wr,
	input  logic [31:0]          q_addr,
	input  logic [SET_W-1:0]     q_set,
	input  logic [TAG_W-1:0]     q_tag,
	output scac_pkg::back_stat_t stat,
	output logic                 oq_wen,
	output scac_pkg::out_item_t  oq_wdata,
	input  logic                 oq_full
);
	import scac_pkg::*;

	localparam int WAY_W  = 2 + TAG_W + 32;
	localparam int ROW_W  = WAYS * WAY_W;
	localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

	back_state_t        state_q, state_d;
	logic [SET_W-1:0]   cnt_q;
	logic               wr_q;
	logic [31:0]        addr_q;
	logic [SET_W-1:0]   set_q;
	logic [TAG_W-1:0]   tag_q;
	logic [31:0]        clock_q;
	logic               hit_q;
	logic [WAY_IW-1:0]  way_q, scan_q;
	logic [31:0]        best_q;
	out_item_t          items_q [3];
	logic [1:0]         nitems_q, eidx_q;

	logic               ram_we, ram_re;
	logic [SET_W-1:0]   ram_waddr;
	logic [ROW_W-1:0]   ram_wdata, row;

	logic               hit_c, inv_c;
	logic [WAY_IW-1:0]  hway_c, iway_c;
	out_item_t          items_c [3];
	logic [1:0]         nitems_c;
	logic [ROW_W-1:0]   newrow_c;
	logic [WAY_W-1:0]   vic_c;
	logic [31:0]        old_c, use_scan;

	scac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (q_set),
		.rdata (row)
	);

	// lookup: hit way and first invalid way (way 1 upward, then way 0)
	always_comb begin
		hit_c  = 1'b0;
		hway_c = '0;
		inv_c  = 1'b0;
		iway_c = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w*WAY_W + WAY_W-1] && row[w*WAY_W + 32 +: TAG_W] == tag_q) begin
				hit_c  = 1'b1;
				hway_c = WAY_IW'(w);
			end
		end
		for (int w = WAYS - 1; w >= 1; w--) begin
			if (!row[w*WAY_W + WAY_W-1]) begin
				inv_c  = 1'b1;
				iway_c = WAY_IW'(w);
			end
		end
		if (!inv_c && !row[WAY_W-1]) begin
			inv_c  = 1'b1;
			iway_c = '0;
		end
	end

	assign use_scan = row[32'(scan_q)*WAY_W +: 32];

	// set update and result list
	always_comb begin
		vic_c    = row[32'(way_q)*WAY_W +: WAY_W];
		old_c    = 32'((32'(vic_c[32 +: TAG_W]) * 32'(SETS) + 32'(set_q)) * 32'(LINE_BYTES));
		newrow_c = row;
		nitems_c = 2'd0;
		for (int i = 0; i < 3; i++) begin
			items_c[i] = '{kind: KIND_DONE, addr: addr_q, hit: 1'b0, last: 1'b0};
		end
		if (hit_q) begin
			newrow_c[32'(way_q)*WAY_W +: 32] = clock_q + 32'd1;
			if (wr_q && write_policy) newrow_c[32'(way_q)*WAY_W + WAY_W-2] = 1'b1;
			if (wr_q && !write_policy) begin
				items_c[0] = '{kind: KIND_WRITE, addr: addr_q, hit: 1'b0, last: 1'b0};
				nitems_c   = 2'd1;
			end
			items_c[nitems_c] = '{kind: KIND_DONE, addr: addr_q, hit: 1'b1, last: 1'b1};
		end else begin
			items_c[0] = '{kind: KIND_READ, addr: addr_q, hit: 1'b0, last: 1'b0};
			nitems_c   = 2'd1;
			if (vic_c[WAY_W-1] && vic_c[WAY_W-2] && write_policy) begin
				items_c[1] = '{kind: KIND_WRITE, addr: old_c, hit: 1'b0, last: 1'b0};
				nitems_c   = 2'd2;
			end
			if (wr_q && !write_policy) begin
				items_c[1] = '{kind: KIND_WRITE, addr: addr_q, hit: 1'b0, last: 1'b0};
				nitems_c   = 2'd2;
			end
			items_c[nitems_c] = '{kind: KIND_DONE, addr: addr_q, hit: 1'b0, last: 1'b1};
			newrow_c[32'(way_q)*WAY_W +: WAY_W] =
				{1'b1, wr_q && write_policy, tag_q, clock_q + 32'd1};
		end
		nitems_c = nitems_c + 2'd1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (cnt_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (q_valid) state_d = ST_LOOK;
			ST_LOOK: begin
				if (hit_c || inv_c || WAYS == 1) state_d = ST_UPD;
				else state_d = ST_SCAN;
			end
			ST_SCAN:  if (scan_q == WAY_IW'(WAYS - 1)) state_d = ST_UPD;
			ST_UPD:   state_d = ST_EMIT;
			ST_EMIT:  if (!oq_full && eidx_q == nitems_q - 2'd1) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = set_q;
		ram_wdata     = newrow_c;
		ram_re        = 1'b0;
		stat.clearing = 1'b0;
		stat.pop      = 1'b0;
		oq_wen        = 1'b0;
		oq_wdata      = items_q[eidx_q];
		case (state_q)
			ST_CLEAR: begin
				stat.clearing = 1'b1;
				ram_we        = 1'b1;
				ram_waddr     = cnt_q;
				ram_wdata     = '0;
			end
			ST_IDLE: begin
				ram_re   = q_valid;
				stat.pop = q_valid;
			end
			ST_UPD:  ram_we = 1'b1;
			ST_EMIT: oq_wen = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				wr_q   <= q_wr;
				addr_q <= q_addr;
				set_q  <= q_set;
				tag_q  <= q_tag;
			end
			ST_LOOK: begin
				hit_q  <= hit_c;
				way_q  <= hit_c ? hway_c : iway_c;
				best_q <= row[31:0];
				scan_q <= WAY_IW'(1 % WAYS);
			end
			ST_SCAN: begin
				if (use_scan < best_q) begin
					best_q <= use_scan;
					way_q  <= scan_q;
				end
				scan_q <= scan_q + WAY_IW'(1);
			end
			ST_UPD: begin
				for (int i = 0; i < 3; i++) items_q[i] <= items_c[i];
				nitems_q <= nitems_c;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			clock_q <= '0;
			eidx_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) cnt_q <= cnt_q + SET_W'(1);
			if (state_q == ST_UPD) begin
				clock_q <= clock_q + 32'd1;
				eidx_q  <= 2'd0;
			end
			if (state_q == ST_EMIT && !oq_full) eidx_q <= eidx_q + 2'd1;
		end
	end
endmodule

// File: sv/set_assoc_cache_lru_controller_unit.sv
// Path: push, front queue, row read (IDLE), lookup (LOOK), LRU scan (SCAN), row
//   write (UPD), result emit (EMIT); the LRU scan of one way a cycle runs only on a
//   miss into a full set; the back part takes a new access only after emitting the
//   last result of the one before, each a read-modify-write of one tag/use RAM row.
// Reset: arst_n clears control state; the block then clears the RAM one set per
//   cycle and holds full high until that pass ends.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller_unit
// Tag and policy controller of a set-associative write-allocate cache with
// timestamp LRU, write-back or write-through.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_cache_lru_controller_unit #(
	parameter int LINE_BYTES = scac_pkg::LINE_BYTES_DEF,
	parameter int SETS       = scac_pkg::SETS_DEF,
	parameter int WAYS       = scac_pkg::WAYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// access input queue
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic [31:0]        access_address,
	// result output queue
	output logic               empty,
	input  logic               pop,
	output scac_pkg::kind_t    item_kind,
	output logic [31:0]        request_address,
	output logic               was_hit,
	output logic               last_item,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import scac_pkg::*;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam longint SPAN = longint'(LINE_BYTES) * longint'(SETS);
	localparam int TAG_RAW = $clog2((64'd4294967295 / SPAN) + 1);
	localparam int TAG_W = (TAG_RAW > 0) ? TAG_RAW : 1;

	logic              write_policy_q;
	back_stat_t        stat;
	logic              q_valid, q_wr;
	logic [31:0]       q_addr;
	logic [SET_W-1:0]  q_set;
	logic [TAG_W-1:0]  q_tag;
	logic              oq_wen, oq_full;
	out_item_t         oq_wdata, head;

	// configuration: writes land in the access cycle; pready is tied high
	assign pready = 1'b1;
	assign prdata = (paddr == REG_WRITE_POLICY) ? {31'd0, write_policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_policy_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr == REG_WRITE_POLICY) begin
			write_policy_q <= pwdata[0];
		end
	end

	// front: accept and classify each access into set and tag
	scac_front #(
		.SET_W(SET_W), .TAG_W(TAG_W), .LINE_BYTES(LINE_BYTES), .SETS(SETS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.action         (action),
		.access_address (access_address),
		.stat           (stat),
		.q_valid        (q_valid),
		.q_wr           (q_wr),
		.q_addr         (q_addr),
		.q_set          (q_set),
		.q_tag          (q_tag)
	);

	// back: set lookup, victim choice, set update, result transfer
	scac_back #(
		.SET_W(SET_W), .TAG_W(TAG_W), .LINE_BYTES(LINE_BYTES), .SETS(SETS), .WAYS(WAYS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_policy (write_policy_q),
		.q_valid      (q_valid),
		.q_wr         (q_wr),
		.q_addr       (q_addr),
		.q_set        (q_set),
		.q_tag        (q_tag),
		.stat         (stat),
		.oq_wen       (oq_wen),
		.oq_wdata     (oq_wdata),
		.oq_full      (oq_full)
	);

	// result queue: decouples the back part from the consumer
	scac_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (oq_wen),
		.wdata  (oq_wdata),
		.wfull  (oq_full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	assign item_kind       = head.kind;
	assign request_address = head.addr;
	assign was_hit         = head.hit;
	assign last_item       = head.last;

	`ASSERT_IMPL(a_last_is_done, clk, arst_n, !empty && last_item, item_kind == KIND_DONE)
	`ASSERT_IMPL(a_hit_on_done, clk, arst_n, !empty && item_kind != KIND_DONE, !was_hit)
	`ASSERT_NEXT(a_pop_moves, clk, arst_n, stat.pop, !stat.pop)
endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the set-associative cache controller: drives read and
// write accesses through the push/full queue, predicts the next-level traffic
// and completion items with a behavioral tag/LRU model, and checks every
// transfer popped from the result queue under both write policies.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import scac_pkg::*;

	localparam int LB = 64;
	localparam int NSETS = 64;
	localparam int NWAYS = 4;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        wr;
		logic [31:0] addr;
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic action = 1'b0;
	logic [31:0] access_address = '0;
	logic pop = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic full, empty, was_hit, last_item, pready;
	kind_t item_kind;
	logic [31:0] request_address, prdata;

	set_assoc_cache_lru_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .action(action), .access_address(access_address),
		.empty(empty), .pop(pop), .item_kind(item_kind),
		.request_address(request_address), .was_hit(was_hit), .last_item(last_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// cache shadow state
	logic        shadow_wb;
	logic        tag_valid [NSETS*NWAYS];
	logic        tag_dirty [NSETS*NWAYS];
	logic [19:0] tag_mem [NSETS*NWAYS];
	logic [31:0] use_stamp [NSETS*NWAYS];
	logic [31:0] use_clock;

	out_item_t   expected_items[$];
	access_t     pending_accesses[$];
	int          mismatches = 0;
	int          cycles = 0;
	int          hits_seen = 0;
	int          writebacks_seen = 0;
	int          transfers_checked = 0;
	bit          quiet_tail = 0;
	bit          rx_hold = 0;

	function automatic out_item_t mk(kind_t k, logic [31:0] a, logic h, logic l);
		out_item_t r;
		r.kind = k; r.addr = a; r.hit = h; r.last = l;
		return r;
	endfunction

	// Advance the shadow cache by one access and queue the traffic it causes.
	task automatic predict_access(input access_t acc);
		logic [25:0] line;
		logic [5:0]  set;
		logic [19:0] tag;
		int base, way, victim;
		bit found;
		logic [31:0] least;
		found = 0; way = 0;
		use_clock = use_clock + 32'd1;
		line = acc.addr[31:6];
		set = line[5:0];
		tag = line[25:6];
		base = set * NWAYS;
		for (int w = 0; w < NWAYS; w++)
			if (!found && tag_valid[base+w] && tag_mem[base+w] == tag) begin
				found = 1; way = w;
			end
		if (found) begin
			use_stamp[base+way] = use_clock;
			if (acc.wr && shadow_wb) tag_dirty[base+way] = 1;
			if (acc.wr && !shadow_wb) expected_items.push_back(mk(KIND_WRITE, acc.addr, 0, 0));
			expected_items.push_back(mk(KIND_DONE, acc.addr, 1, 1));
			return;
		end
		expected_items.push_back(mk(KIND_READ, acc.addr, 0, 0));
		// victim: first free way from 1 up, then way 0, then oldest stamp
		victim = -1;
		for (int w = 1; w < NWAYS; w++)
			if (victim < 0 && !tag_valid[base+w]) victim = w;
		if (victim < 0 && !tag_valid[base]) victim = 0;
		if (victim < 0) begin
			victim = 0; least = use_stamp[base];
			for (int w = 1; w < NWAYS; w++)
				if (use_stamp[base+w] < least) begin
					least = use_stamp[base+w]; victim = w;
				end
		end
		if (tag_valid[base+victim] && tag_dirty[base+victim] && shadow_wb)
			expected_items.push_back(mk(KIND_WRITE,
				{tag_mem[base+victim], set, 6'd0}, 0, 0));
		tag_valid[base+victim] = 1;
		tag_mem[base+victim] = tag;
		use_stamp[base+victim] = use_clock;
		tag_dirty[base+victim] = acc.wr && shadow_wb;
		if (acc.wr && !shadow_wb) expected_items.push_back(mk(KIND_WRITE, acc.addr, 0, 0));
		expected_items.push_back(mk(KIND_DONE, acc.addr, 0, 1));
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
		mismatches++;
	endtask

	// Driver: offer queued accesses, idle in short random bursts.
	int tx_gap = 0;
	always @(posedge clk) begin
		if (push && !full) begin
			predict_access(pending_accesses.pop_front());
		end
		if (!(push && !full) && push) begin
			// hold the current offer until it transfers
		end else if (tx_gap > 0 || pending_accesses.size() == 0) begin
			push <= 1'b0;
			if (tx_gap > 0) tx_gap <= tx_gap - 1;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			tx_gap <= $urandom_range(0, 3);
		end else begin
			push <= 1'b1;
			action <= pending_accesses[0].wr;
			access_address <= pending_accesses[0].addr;
		end
	end

	// Monitor: pop with random stalls and compare each transfer.
	int rx_gap = 0;
	always @(posedge clk) begin
		out_item_t want;
		cycles <= cycles + 1;
		if (pop && !empty) begin
			if (expected_items.size() == 0) begin
				report_mismatch("unexpected result, request_address", request_address,
					32'd0);
			end else begin
				want = expected_items.pop_front();
				transfers_checked++;
				if (want.kind == KIND_DONE && want.hit) hits_seen++;
				if (want.kind == KIND_WRITE && want.addr[5:0] == 0 && shadow_wb)
					writebacks_seen++;
				if (item_kind !== want.kind)
					report_mismatch("item_kind", 32'(item_kind), 32'(want.kind));
				if (request_address !== want.addr)
					report_mismatch("request_address", request_address, want.addr);
				if (was_hit !== want.hit)
					report_mismatch("was_hit", 32'(was_hit), 32'(want.hit));
				if (last_item !== want.last)
					report_mismatch("last_item", 32'(last_item), 32'(want.last));
			end
		end
		if (rx_hold) begin
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			pop <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			rx_gap <= $urandom_range(0, 3);
		end else begin
			pop <= 1'b1;
		end
	end

	// Abort a run that hangs.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("set_assoc_cache_lru_controller_unit regression: fail");
			$finish;
		end
	end

	task automatic write_policy_reg(input logic wb);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(REG_WRITE_POLICY) * 3'd4; pwdata <= {31'd0, wb};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		shadow_wb = wb;
	endtask

	task automatic drain();
		while (pending_accesses.size() != 0 || push || expected_items.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Build an address from set, tag and byte offset.
	function automatic logic [31:0] addr_of(logic [19:0] tag, logic [5:0] set,
			logic [5:0] ofs);
		return {tag, set, ofs};
	endfunction

	// Random access biased onto few tags so hits, fills and evictions all occur.
	function automatic access_t random_access();
		access_t a;
		a.wr = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) a.addr = $urandom;
		else a.addr = addr_of(
			20'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 20'hFFFF8 : 20'd0),
			6'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 6'h3C : 6'd0),
			6'($urandom));
		return a;
	endfunction

	task automatic queue_access(input logic wr, input logic [31:0] a);
		access_t x;
		x.wr = wr; x.addr = a;
		pending_accesses.push_back(x);
	endtask

	initial begin
		shadow_wb = 1;
		use_clock = '0;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			tag_valid[i] = 0; tag_dirty[i] = 0; tag_mem[i] = '0; use_stamp[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: fill one set past its ways under write-back, dirty
		// victims, hits, address extremes.
		queue_access(1, 32'h0000_0000);
		queue_access(1, 32'hFFFF_FFFF);
		queue_access(0, 32'h0000_003F);
		for (int t = 1; t <= 5; t++) queue_access(t[0], addr_of(20'(t), 6'd5, 6'd7));
		queue_access(0, addr_of(20'd2, 6'd5, 6'd0));
		queue_access(1, addr_of(20'd9, 6'd5, 6'd1));
		queue_access(0, addr_of(20'd10, 6'd5, 6'd2));
		queue_access(0, 32'hFFFF_FFC0);
		drain();

		// Write-through: hits and misses forward writes, dirty victims dropped.
		write_policy_reg(0);
		queue_access(1, addr_of(20'd2, 6'd5, 6'd3));
		queue_access(1, addr_of(20'd11, 6'd5, 6'd4));
		queue_access(1, addr_of(20'd12, 6'd5, 6'd4));
		queue_access(0, 32'h5555_5555);
		queue_access(1, 32'hAAAA_AAAA);
		drain();

		// Long receiver hold while the sender keeps offering.
		write_policy_reg(1);
		for (int i = 0; i < 40; i++) begin
			access_t a;
			a = random_access();
			pending_accesses.push_back(a);
		end
		rx_hold = 1;
		repeat (300) @(posedge clk);
		rx_hold = 0;
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_policy_reg(ph[0]);
			if (ph == 3) quiet_tail = 1;
			for (int i = 0; i < 40; i++) begin
				access_t a;
				a = random_access();
				pending_accesses.push_back(a);
			end
			drain();
		end

		$display("checked %0d result transfers: %0d hits, %0d line write-backs,",
			transfers_checked, hits_seen, writebacks_seen);
		$display("both write policies, full-set LRU evictions and a long output stall");
		if (mismatches == 0) begin
			$display("set_assoc_cache_lru_controller_unit regression: pass");
		end else begin
			$display("set_assoc_cache_lru_controller_unit regression: fail");
		end
		$finish;
	end
endmodule
